### src/clnf_pkg.sv
// Shared types, codes and character constants for the character display number formatter.
package clnf_pkg;

    localparam logic [2:0] MODE_CHAR = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_SDEC = 3'd2;
    localparam logic [2:0] MODE_HEX  = 3'd3;
    localparam logic [2:0] MODE_BIN  = 3'd4;

    localparam logic [7:0] SET_ADDR_CMD = 8'h80;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_A      = 8'h41;
    localparam logic [7:0] ASCII_PLUS   = 8'h2B;
    localparam logic [7:0] ASCII_MINUS  = 8'h2D;
    localparam logic [3:0] DEC_RADIX    = 4'd10;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  line;
        logic [5:0]  column;
        logic [15:0] value;
        logic [4:0]  digit_count;
    } nf_in_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } nf_out_t;

    // Request as it travels down the pipe once decoded.
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] cmd;
        logic       neg;
        logic [5:0] count;
    } nf_job_t;

    function automatic logic [7:0] ascii_digit(input logic [3:0] d);
        logic [7:0] r;
        if (d < DEC_RADIX) begin
            r = ASCII_ZERO + {4'd0, d};
        end else begin
            r = ASCII_A + {4'd0, d} - {4'd0, DEC_RADIX};
        end
        return r;
    endfunction

endpackage

### src/clnf_front.sv
// Front stage: address command, digit count clip, sign and magnitude.
module clnf_front #(
    parameter int MAX_DIGITS = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  clnf_pkg::nf_in_t      s_data,
    output logic                  job_valid,
    input  logic                  job_ready,
    output clnf_pkg::nf_job_t     job,
    output logic [VALUE_BITS-1:0] mag
);
    import clnf_pkg::*;

    localparam int IW = (VALUE_BITS > 16) ? VALUE_BITS : 16;

    logic                  valid_reg;
    nf_job_t               job_reg;
    nf_job_t               job_next;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [IW-1:0]         vext;
    logic [VALUE_BITS-1:0] v;
    logic [7:0]            ofs;

    assign s_ready = !valid_reg || job_ready;

    always_comb begin
        vext = IW'(s_data.value);
        v    = vext[VALUE_BITS-1:0];
        ofs  = (s_data.line == 2'd1) ? 8'd0 : LINE2_OFFSET;
        job_next.mode = s_data.mode;
        // column zero wraps the address around
        job_next.cmd  = SET_ADDR_CMD | (8'(s_data.column) - 8'd1 + ofs);
        job_next.neg  = (s_data.mode == MODE_SDEC) && v[VALUE_BITS-1];
        if ({1'b0, s_data.digit_count} > 6'(MAX_DIGITS)) begin
            job_next.count = 6'(MAX_DIGITS);
        end else begin
            job_next.count = {1'b0, s_data.digit_count};
        end
        mag_next = job_next.neg ? (~v + 1'b1) : v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            job_reg <= job_next;
            mag_reg <= mag_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;
    assign mag       = mag_reg;

endmodule

### src/clnf_bcd.sv
// Pipelined binary to BCD conversion, four magnitude bits per stage.
module clnf_bcd #(
    parameter int VALUE_BITS = 16,
    parameter int BCD_DIGITS = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  clnf_pkg::nf_job_t       in_job,
    input  logic [VALUE_BITS-1:0]   in_mag,
    output logic                    out_valid,
    input  logic                    out_ready,
    output clnf_pkg::nf_job_t       out_job,
    output logic [VALUE_BITS-1:0]   out_mag,
    output logic [4*BCD_DIGITS-1:0] out_bcd
);
    import clnf_pkg::*;

    localparam int BW  = 4 * BCD_DIGITS;
    localparam int NS  = (VALUE_BITS + 3) / 4;
    localparam int PMW = 4 * NS;

    logic                  v_reg   [NS];
    nf_job_t               job_reg [NS];
    logic [VALUE_BITS-1:0] mag_reg [NS];
    logic [BW-1:0]         bcd_reg [NS];
    logic                  rdy     [NS+1];

    function automatic logic [BW-1:0] dabble(input logic [BW-1:0] b, input logic bit_in);
        logic [BW-1:0] t;
        t = b;
        for (int j = 0; j < BCD_DIGITS; j++) begin
            if (t[4*j +: 4] >= 4'd5) begin
                t[4*j +: 4] = t[4*j +: 4] + 4'd3;
            end
        end
        return {t[BW-2:0], bit_in};
    endfunction

    assign rdy[NS]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic                  sv;
        nf_job_t               sjob;
        logic [VALUE_BITS-1:0] smag;
        logic [PMW-1:0]        spad;
        logic [BW-1:0]         sbcd_in;
        logic [BW-1:0]         bcd_next;

        if (s == 0) begin : g_first
            assign sv      = in_valid;
            assign sjob    = in_job;
            assign smag    = in_mag;
            assign sbcd_in = '0;
        end else begin : g_rest
            assign sv      = v_reg[s-1];
            assign sjob    = job_reg[s-1];
            assign smag    = mag_reg[s-1];
            assign sbcd_in = bcd_reg[s-1];
        end

        assign rdy[s] = !v_reg[s] || rdy[s+1];
        // magnitude left-aligned so each stage picks its bits at fixed places
        assign spad   = PMW'({smag, (PMW - VALUE_BITS + 1)'(0)} >> 1);

        always_comb begin
            bcd_next = sbcd_in;
            for (int k = 0; k < 4; k++) begin
                if (4 * s + k < VALUE_BITS) begin
                    bcd_next = dabble(bcd_next, spad[PMW-1-4*s-k]);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (rdy[s]) begin
                v_reg[s] <= sv;
            end
            if (rdy[s] && sv) begin
                job_reg[s] <= sjob;
                mag_reg[s] <= smag;
                bcd_reg[s] <= bcd_next;
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_job   = job_reg[NS-1];
    assign out_mag   = mag_reg[NS-1];
    assign out_bcd   = bcd_reg[NS-1];

endmodule

### src/clnf_emit.sv
// Byte sequencer: command byte, then a character, or an optional sign and digits, into the output register.
module clnf_emit #(
    parameter int MAX_DIGITS = 16,
    parameter int VALUE_BITS = 16,
    parameter int BCD_DIGITS = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  clnf_pkg::nf_job_t       in_job,
    input  logic [VALUE_BITS-1:0]   in_mag,
    input  logic [4*BCD_DIGITS-1:0] in_bcd,
    output logic                    m_valid,
    input  logic                    m_ready,
    output clnf_pkg::nf_out_t       m_data
);
    import clnf_pkg::*;

    localparam int DW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int MPW = (VALUE_BITS > 4 * MAX_DIGITS) ? VALUE_BITS : 4 * MAX_DIGITS;
    localparam int BPW = (BCD_DIGITS > MAX_DIGITS) ? 4 * BCD_DIGITS : 4 * MAX_DIGITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_CHR,
        ST_SIGN,
        ST_DIG
    } emit_state_t;

    emit_state_t     state_reg, state_next;
    nf_job_t         job_reg, job_next;
    logic [7:0]      chr_reg, chr_next;
    logic [3:0]      dig_reg  [MAX_DIGITS];
    logic [3:0]      dig_next [MAX_DIGITS];
    logic [DW-1:0]   d_reg, d_next;
    logic            m_valid_reg, m_valid_next;
    nf_out_t         m_data_reg, m_data_next;
    logic [MPW-1:0]  magp;
    logic [BPW-1:0]  bcdp;
    logic            out_free;
    logic            plain_num;

    assign magp      = MPW'(in_mag);
    assign bcdp      = BPW'(in_bcd);
    assign out_free  = !m_valid_reg || m_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign plain_num = (job_reg.mode == MODE_UDEC) || (job_reg.mode == MODE_HEX) ||
                       (job_reg.mode == MODE_BIN);

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        chr_next     = chr_reg;
        d_next       = d_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            dig_next[i] = dig_reg[i];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    job_next   = in_job;
                    chr_next   = magp[7:0];
                    state_next = ST_CMD;
                    for (int i = 0; i < MAX_DIGITS; i++) begin
                        case (in_job.mode)
                            MODE_HEX: dig_next[i] = magp[4*i +: 4];
                            MODE_BIN: dig_next[i] = {3'd0, magp[i]};
                            default:  dig_next[i] = bcdp[4*i +: 4];
                        endcase
                    end
                end
            end
            ST_CMD: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.is_data  = 1'b0;
                    m_data_next.bus_byte = job_reg.cmd;
                    m_data_next.last     = 1'b1;
                    state_next           = ST_IDLE;
                    d_next               = DW'(job_reg.count - 6'd1);
                    if (job_reg.mode == MODE_CHAR) begin
                        m_data_next.last = 1'b0;
                        state_next       = ST_CHR;
                    end else if (job_reg.mode == MODE_SDEC) begin
                        m_data_next.last = 1'b0;
                        state_next       = ST_SIGN;
                    end else if (plain_num && job_reg.count != 6'd0) begin
                        m_data_next.last = 1'b0;
                        state_next       = ST_DIG;
                    end
                end
            end
            ST_CHR: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.is_data  = 1'b1;
                    m_data_next.bus_byte = chr_reg;
                    m_data_next.last     = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.is_data  = 1'b1;
                    m_data_next.bus_byte = job_reg.neg ? ASCII_MINUS : ASCII_PLUS;
                    m_data_next.last     = (job_reg.count == 6'd0);
                    state_next           = (job_reg.count == 6'd0) ? ST_IDLE : ST_DIG;
                end
            end
            ST_DIG: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.is_data  = 1'b1;
                    m_data_next.bus_byte = ascii_digit(dig_reg[d_reg]);
                    m_data_next.last     = (d_reg == '0);
                    d_next               = d_reg - 1'b1;
                    if (d_reg == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        job_reg    <= job_next;
        chr_reg    <= chr_next;
        d_reg      <= d_next;
        m_data_reg <= m_data_next;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            dig_reg[i] <= dig_next[i];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/char_lcd_number_formatter.sv
// Top level of the character display number formatter.
//
//   port group  dir  payload                                   beat moves
//   s_*         in   nf_in_t  {mode,line,column,value,digits}  one display request
//   m_*         out  nf_out_t {is_data,bus_byte,last}          one controller byte
//
// A request passes a decode stage and ceil(VALUE_BITS/4) BCD stages, then the
// byte sequencer, which loads the request, then sends its bytes one by one and
// takes no new request before its last byte is issued. The sequencer sets the rate;
// the stages ahead of it keep filling while it works. aresetn is synchronous and
// clears all valid bits and the sequencer state. A stall on m_ready holds the
// output register and backs up through every stage without loss.
module char_lcd_number_formatter #(
    parameter int MAX_DIGITS = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  clnf_pkg::nf_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output clnf_pkg::nf_out_t m_data
);
    import clnf_pkg::*;

    function automatic int dec_digits(input int bits);
        longint unsigned m;
        int n;
        m = (64'd1 << bits) - 64'd1;
        n = 0;
        for (int i = 0; i < 20; i++) begin
            if (m != 0) begin
                m = m / 10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int BCD_DIGITS = dec_digits(VALUE_BITS);

    logic                    f_valid, f_ready;
    nf_job_t                 f_job;
    logic [VALUE_BITS-1:0]   f_mag;
    logic                    b_valid, b_ready;
    nf_job_t                 b_job;
    logic [VALUE_BITS-1:0]   b_mag;
    logic [4*BCD_DIGITS-1:0] b_bcd;

    clnf_front #(
        .MAX_DIGITS(MAX_DIGITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job),
        .mag       (f_mag)
    );

    clnf_bcd #(
        .VALUE_BITS(VALUE_BITS),
        .BCD_DIGITS(BCD_DIGITS)
    ) u_bcd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_job    (f_job),
        .in_mag    (f_mag),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_job   (b_job),
        .out_mag   (b_mag),
        .out_bcd   (b_bcd)
    );

    clnf_emit #(
        .MAX_DIGITS(MAX_DIGITS),
        .VALUE_BITS(VALUE_BITS),
        .BCD_DIGITS(BCD_DIGITS)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_job   (b_job),
        .in_mag   (b_mag),
        .in_bcd   (b_bcd),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### sim/char_lcd_number_formatter_test.sv
// Self-checking testbench for the character display number formatter.
`timescale 1ns / 100ps

module char_lcd_number_formatter_test;
    import clnf_pkg::*;

    localparam logic [2:0] MODE_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNDEF_LAST  = 3'd7;
    localparam int unsigned RADIX_BIN = 2;
    localparam int unsigned RADIX_DEC = 10;
    localparam int unsigned RADIX_HEX = 16;
    localparam int MAX_SHOWN     = 16;
    localparam int TABLE_ROWS    = 25;
    localparam int RANDOM_ITEMS  = 305;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        nf_in_t  req;
        int      n_typed;
        nf_out_t t0;
        nf_out_t t1;
    } request_row_t;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    nf_in_t  s_data;
    logic    m_valid;
    logic    m_ready;
    nf_out_t m_data;

    nf_out_t      display_bytes_due [$];
    request_row_t request_table [TABLE_ROWS];
    int           mismatch_count = 0;
    int           beats_checked  = 0;
    int           requests_sent  = 0;
    int           cycle_count    = 0;
    bit           calm           = 1'b0;
    bit           long_hold_req  = 1'b0;

    char_lcd_number_formatter u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic nf_in_t req_of(input logic [2:0] mode, input logic [1:0] line,
                                      input logic [5:0] column, input logic [15:0] value,
                                      input logic [4:0] digit_count);
        nf_in_t r;
        r.mode        = mode;
        r.line        = line;
        r.column      = column;
        r.value       = value;
        r.digit_count = digit_count;
        return r;
    endfunction

    function automatic nf_out_t byte_of(input logic is_data, input logic [7:0] bus_byte,
                                        input logic last);
        nf_out_t b;
        b.is_data  = is_data;
        b.bus_byte = bus_byte;
        b.last     = last;
        return b;
    endfunction

    // Expand one request into the controller bytes it must produce.
    function automatic void format_request(input nf_in_t r);
        nf_out_t     seq [18];
        logic [7:0]  digs [16];
        logic [7:0]  addr;
        logic [7:0]  ch;
        logic [16:0] v;
        int unsigned radix;
        int          count;
        int          n;
        count = (r.digit_count > MAX_SHOWN) ? MAX_SHOWN : int'(r.digit_count);
        // address wraps modulo 256 before the command bit is or'd in
        addr = {2'b00, r.column} - 8'd1 + ((r.line == 2'd1) ? 8'h00 : LINE2_OFFSET);
        seq[0] = byte_of(1'b0, SET_ADDR_CMD | addr, 1'b0);
        n = 1;
        radix = 0;
        v = {1'b0, r.value};
        case (r.mode)
            MODE_CHAR: begin
                seq[1] = byte_of(1'b1, r.value[7:0], 1'b0);
                n = 2;
            end
            MODE_UDEC: radix = RADIX_DEC;
            MODE_SDEC: begin
                radix = RADIX_DEC;
                seq[1] = byte_of(1'b1, r.value[15] ? ASCII_MINUS : ASCII_PLUS, 1'b0);
                n = 2;
                if (r.value[15]) v = 17'h10000 - {1'b0, r.value};
            end
            MODE_HEX: radix = RADIX_HEX;
            MODE_BIN: radix = RADIX_BIN;
            default: ;
        endcase
        if (radix != 0) begin
            for (int i = 0; i < count; i++) begin
                digs[i] = 8'(v % radix);
                v = 17'(v / radix);
            end
            for (int i = count - 1; i >= 0; i--) begin
                if (digs[i] < RADIX_DEC) ch = ASCII_ZERO + digs[i];
                else ch = ASCII_A + digs[i] - 8'(RADIX_DEC);
                seq[n] = byte_of(1'b1, ch, 1'b0);
                n++;
            end
        end
        seq[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) display_bytes_due.push_back(seq[i]);
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic offer(input nf_in_t req);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    initial begin
        nf_in_t req;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        request_table = '{
            '{req_of(MODE_CHAR, 2'd1, 6'd1, 16'h0041, 5'd0), 2,
              byte_of(1'b0, 8'h80, 1'b0), byte_of(1'b1, 8'h41, 1'b1)},
            '{req_of(MODE_CHAR, 2'd2, 6'd40, 16'hFF7E, 5'd31), 2,
              byte_of(1'b0, 8'hE7, 1'b0), byte_of(1'b1, 8'h7E, 1'b1)},
            '{req_of(MODE_CHAR, 2'd1, 6'd1, 16'h00FF, 5'd16), 2,
              byte_of(1'b0, 8'h80, 1'b0), byte_of(1'b1, 8'hFF, 1'b1)},
            '{req_of(MODE_UDEC, 2'd1, 6'd0, 16'h1234, 5'd0), 1,
              byte_of(1'b0, 8'hFF, 1'b1), '0},
            '{req_of(MODE_HEX, 2'd2, 6'd0, 16'hFFFF, 5'd0), 1,
              byte_of(1'b0, 8'hBF, 1'b1), '0},
            '{req_of(MODE_UNDEF_FIRST, 2'd1, 6'd1, 16'h1234, 5'd5), 1,
              byte_of(1'b0, 8'h80, 1'b1), '0},
            '{req_of(MODE_UNDEF_LAST, 2'd3, 6'd63, 16'hFFFF, 5'd31), 1,
              byte_of(1'b0, 8'hFE, 1'b1), '0},
            '{req_of(MODE_SDEC, 2'd1, 6'd1, 16'h8000, 5'd0), 2,
              byte_of(1'b0, 8'h80, 1'b0), byte_of(1'b1, ASCII_MINUS, 1'b1)},
            '{req_of(MODE_SDEC, 2'd1, 6'd1, 16'h0000, 5'd0), 2,
              byte_of(1'b0, 8'h80, 1'b0), byte_of(1'b1, ASCII_PLUS, 1'b1)},
            '{req_of(MODE_BIN, 2'd0, 6'd1, 16'h0000, 5'd0), 1,
              byte_of(1'b0, 8'hC0, 1'b1), '0},
            '{req_of(MODE_HEX, 2'd1, 6'd1, 16'h0000, 5'd1), 2,
              byte_of(1'b0, 8'h80, 1'b0), byte_of(1'b1, 8'h30, 1'b1)},
            '{req_of(MODE_HEX, 2'd1, 6'd1, 16'hFFFF, 5'd1), 2,
              byte_of(1'b0, 8'h80, 1'b0), byte_of(1'b1, 8'h46, 1'b1)},
            '{req_of(MODE_UDEC, 2'd1, 6'd5, 16'hFFFF, 5'd5), 0, '0, '0},
            '{req_of(MODE_UDEC, 2'd2, 6'd16, 16'hFFFF, 5'd16), 0, '0, '0},
            '{req_of(MODE_UDEC, 2'd1, 6'd1, 16'd12345, 5'd31), 0, '0, '0},
            '{req_of(MODE_SDEC, 2'd1, 6'd1, 16'h8000, 5'd5), 0, '0, '0},
            '{req_of(MODE_SDEC, 2'd2, 6'd20, 16'h7FFF, 5'd6), 0, '0, '0},
            '{req_of(MODE_SDEC, 2'd1, 6'd2, 16'hFFFF, 5'd3), 0, '0, '0},
            '{req_of(MODE_SDEC, 2'd1, 6'd1, 16'h8000, 5'd16), 0, '0, '0},
            '{req_of(MODE_HEX, 2'd1, 6'd33, 16'hABCD, 5'd16), 0, '0, '0},
            '{req_of(MODE_HEX, 2'd2, 6'd1, 16'h1F2E, 5'd4), 0, '0, '0},
            '{req_of(MODE_BIN, 2'd1, 6'd1, 16'hFFFF, 5'd16), 0, '0, '0},
            '{req_of(MODE_BIN, 2'd2, 6'd40, 16'h5555, 5'd20), 0, '0, '0},
            '{req_of(MODE_BIN, 2'd1, 6'd63, 16'h8001, 5'd16), 0, '0, '0},
            '{req_of(MODE_UDEC, 2'd3, 6'd33, 16'h0000, 5'd10), 0, '0, '0}
        };

        foreach (request_table[i]) begin
            offer(request_table[i].req);
            if (request_table[i].n_typed > 0) begin
                display_bytes_due.push_back(request_table[i].t0);
                if (request_table[i].n_typed > 1) display_bytes_due.push_back(request_table[i].t1);
            end else begin
                format_request(request_table[i].req);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                // some stretches run back to back on both sides
                calm = (n == 80 || n == 160) ? 1'b1 : ($urandom_range(0, 3) == 0);
                // stop the output for a long while and keep feeding the input
                if (n == 80) long_hold_req = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                req.mode = 3'($urandom_range(MODE_UNDEF_FIRST, MODE_UNDEF_LAST));
            else
                req.mode = 3'($urandom_range(MODE_CHAR, MODE_BIN));
            if ($urandom_range(0, 7) == 0) req.line = 2'($urandom_range(0, 3));
            else req.line = 2'($urandom_range(1, 2));
            if ($urandom_range(0, 7) == 0) req.column = 6'($urandom_range(0, 63));
            else req.column = 6'($urandom_range(1, 40));
            case ($urandom_range(0, 7))
                0: req.value = 16'h0000;
                1: req.value = 16'hFFFF;
                2: req.value = 16'h8000;
                3: req.value = 16'h7FFF;
                4: req.value = 16'($urandom_range(0, 99));
                default: req.value = 16'($urandom);
            endcase
            if ($urandom_range(0, 5) == 0) req.digit_count = 5'($urandom_range(17, 31));
            else req.digit_count = 5'($urandom_range(0, 16));
            offer(req);
            format_request(req);
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        while (display_bytes_due.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d requests (%0d from the table) over all modes, lines and counts;",
                 requests_sent, TABLE_ROWS);
        $display("checked %0d output bytes with random stalls and one long output hold.",
                 beats_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Output side: random stall per beat, plus one long hold on request.
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        nf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (display_bytes_due.size() == 0) begin
                $display("%0t: byte with nothing due: is_data=%0b bus_byte=%h last=%0b",
                         $realtime, m_data.is_data, m_data.bus_byte, m_data.last);
                mismatch_count++;
            end else begin
                want = display_bytes_due.pop_front();
                beats_checked++;
                if (m_data.is_data !== want.is_data) begin
                    $display("%0t: is_data expected %0b got %0b",
                             $realtime, want.is_data, m_data.is_data);
                    mismatch_count++;
                end
                if (m_data.bus_byte !== want.bus_byte) begin
                    $display("%0t: bus_byte expected %h got %h",
                             $realtime, want.bus_byte, m_data.bus_byte);
                    mismatch_count++;
                end
                if (m_data.last !== want.last) begin
                    $display("%0t: last expected %0b got %0b",
                             $realtime, want.last, m_data.last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d bytes still due",
                     $realtime, display_bytes_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
